@@ rtl/rast_pkg.sv @@
// Shared definitions for the range aggregate segment tree.
// Field widths, register indexes, request and combine mode codes, identity values.
// No dependencies; imported by rast_combine and range_aggregate_segment_tree_top.
package rast_pkg;

  // Widths of the word fields and configuration registers.
  localparam int DATA_W     = 32;
  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 1'd1;

  // Reset value of the leaf count register.
  localparam logic [COUNT_W-1:0] LEAF_COUNT_RST = 11'd1024;

  // Request types.
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Combine modes. The unused code acts as minimum.
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

  // Identity element of each combine mode.
  function automatic logic [DATA_W-1:0] identity_of(input logic [MODE_W-1:0] mode);
    logic [DATA_W-1:0] res;
    if (mode[1]) begin
      res = INT_MAX;
    end else if (mode == MODE_MAX) begin
      res = INT_MIN;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

@@ rtl/rast_combine.sv @@
// Shared combine unit of the segment tree: wrapping sum, signed maximum or minimum.
// Depends on rast_pkg for widths and mode codes.
module rast_combine (
  input  logic [rast_pkg::MODE_W-1:0] mode,
  input  logic [rast_pkg::DATA_W-1:0] x,
  input  logic [rast_pkg::DATA_W-1:0] y,
  output logic [rast_pkg::DATA_W-1:0] z
);
  import rast_pkg::*;

  logic y_lt_x;
  logic x_lt_y;

  assign y_lt_x = $signed(y) < $signed(x);
  assign x_lt_y = $signed(x) < $signed(y);

  // Bit 1 of the mode selects minimum, so the unused code also takes the minimum.
  always_comb begin
    if (mode[1]) begin
      z = y_lt_x ? y : x;
    end else if (mode == MODE_MAX) begin
      z = x_lt_y ? y : x;
    end else begin
      z = x + y;
    end
  end

endmodule

@@ rtl/range_aggregate_segment_tree_top.sv @@
// Top level of the range aggregate segment tree: sequencer, node memory, stacks, ports.
// Depends on rast_pkg and rast_combine.

// The block keeps a segment tree of 2*MAX_LEAVES signed 32-bit nodes in one memory
// with one write and one registered read per cycle, and one shared combine unit does
// all sums, maxima and minima. After reset a clearing pass writes zero to every node,
// one per cycle, and the block takes no word until the pass is done; configuration
// writes are taken at any time. An update walks down one tree level at a time, saving
// each ancestor, adds to the leaf, and on the way up reads the two children of each
// ancestor and writes it back. A query visits nodes from the root down, splitting those
// that straddle the range, and reads every stored node that lies wholly inside it. Only
// one word is worked on at a time; a finished result waits in an output register while
// the next word is taken.
module range_aggregate_segment_tree_top #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rast_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rast_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [rast_pkg::INDEX_W-1:0]        first_index,
  input  logic [rast_pkg::INDEX_W-1:0]        last_index,
  input  logic signed [rast_pkg::DATA_W-1:0]  add_value,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rast_pkg::DATA_W-1:0]  range_result
);
  import rast_pkg::*;

  localparam int LW    = $clog2(MAX_LEAVES);
  localparam int VW    = (LW + 1 > COUNT_W) ? LW + 1 : COUNT_W;
  localparam int DEPTH = 2 * MAX_LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 2;
  localparam int SD    = LW + 1;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_QVISIT = 4'd2;
  localparam logic [3:0] S_QACC   = 4'd3;
  localparam logic [3:0] S_EMIT   = 4'd4;
  localparam logic [3:0] S_UDESC  = 4'd5;
  localparam logic [3:0] S_ULEAF  = 4'd6;
  localparam logic [3:0] S_UUP    = 4'd7;
  localparam logic [3:0] S_URDR   = 4'd8;
  localparam logic [3:0] S_UWR    = 4'd9;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [VW-1:0] span_a;
    logic [VW-1:0] span_b;
  } stk_entry_t;

  // Configuration registers.
  logic [COUNT_W-1:0] leaf_count;
  logic [MODE_W-1:0]  combine_mode;

  // Sequencer registers.
  logic [3:0]        state, state_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [MODE_W-1:0] mode, mode_next;
  logic [VW-1:0]     lo, lo_next;
  logic [VW-1:0]     hi, hi_next;
  logic [DATA_W-1:0] amount, amount_next;
  logic [NW-1:0]     node, node_next;
  logic [VW-1:0]     span_a, span_a_next;
  logic [VW-1:0]     span_b, span_b_next;
  logic [DATA_W-1:0] acc, acc_next;
  logic [DATA_W-1:0] lval, lval_next;
  logic [SPW-1:0]    sp, sp_next;
  logic [DATA_W-1:0] result;

  // Traversal stack.
  stk_entry_t stack [SD];
  stk_entry_t push_entry;
  stk_entry_t stk_top;
  logic       push;
  logic       do_pop;
  logic [SPW-1:0] sp_m1;

  // Node memory.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_rd;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;

  // Shared combine unit operands.
  logic [MODE_W-1:0] cmb_mode;
  logic [DATA_W-1:0] cmb_x;
  logic [DATA_W-1:0] cmb_y;
  logic [DATA_W-1:0] cmb_z;

  // Derived values.
  logic [VW-1:0]     lc_ext;
  logic [VW-1:0]     n_used;
  logic [VW-1:0]     first_ext;
  logic [VW-1:0]     last_ext;
  logic [VW:0]       span_sum;
  logic [VW-1:0]     mid;
  logic [VW-1:0]     mid_p1;
  logic [NW-1:0]     node_l;
  logic [NW-1:0]     node_r;
  logic [NW-1:0]     top_l;
  logic              in_depth;
  logic [DATA_W-1:0] ident_cur;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign lc_ext    = VW'(leaf_count);
  assign n_used    = (lc_ext > VW'(MAX_LEAVES)) ? VW'(MAX_LEAVES) : lc_ext;
  assign first_ext = VW'(first_index);
  assign last_ext  = VW'(last_index);
  assign span_sum  = {1'b0, span_a} + {1'b0, span_b};
  assign mid       = span_sum[VW:1];
  assign mid_p1    = mid + VW'(1);
  assign node_l    = {node[NW-2:0], 1'b1};
  assign node_r    = {node[NW-2:0], 1'b0} + NW'(2);
  assign in_depth  = node < NW'(DEPTH);
  assign ident_cur = identity_of(mode);
  assign sp_m1     = sp - SPW'(1);
  assign stk_top   = stack[sp_m1[SIW-1:0]];
  assign top_l     = {stk_top.node[NW-2:0], 1'b1};

  rast_combine u_combine (
    .mode (cmb_mode),
    .x    (cmb_x),
    .y    (cmb_y),
    .z    (cmb_z)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    mode_next     = mode;
    lo_next       = lo;
    hi_next       = hi;
    amount_next   = amount;
    node_next     = node;
    span_a_next   = span_a;
    span_b_next   = span_b;
    acc_next      = acc;
    lval_next     = lval;
    sp_next       = sp;
    push          = 1'b0;
    push_entry    = '0;
    do_pop        = 1'b0;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = node[AW-1:0];
    wr_data       = cmb_z;
    rd_addr       = node[AW-1:0];
    cmb_mode      = mode;
    cmb_x         = acc;
    cmb_y         = mem_rd;

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          mode_next   = combine_mode;
          lo_next     = first_ext;
          hi_next     = last_ext;
          amount_next = add_value;
          node_next   = '0;
          span_a_next = '0;
          span_b_next = n_used - VW'(1);
          sp_next     = '0;
          acc_next    = identity_of(combine_mode);
          if (req_type == REQ_QUERY) begin
            state_next = (n_used == '0) ? S_EMIT : S_QVISIT;
          end else if (n_used != '0 && first_ext < n_used) begin
            state_next = S_UDESC;
          end
        end
      end

      // A node outside the range or past the memory adds nothing, a node inside it is read, and a
      // node that straddles the range is split: right half saved, left half next.
      S_QVISIT: begin
        if (!in_depth || span_a > hi || span_b < lo) begin
          do_pop = 1'b1;
        end else if (span_a >= lo && span_b <= hi) begin
          rd_addr    = node[AW-1:0];
          state_next = S_QACC;
        end else begin
          push        = 1'b1;
          push_entry  = '{node: node_r, span_a: mid_p1, span_b: span_b};
          node_next   = node_l;
          span_b_next = mid;
        end
      end

      S_QACC: begin
        acc_next = cmb_z;
        do_pop   = 1'b1;
      end

      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Walk down toward the leaf, saving each ancestor for the way back up.
      S_UDESC: begin
        if (!in_depth) begin
          state_next = S_UUP;
        end else if (span_a == span_b) begin
          rd_addr    = node[AW-1:0];
          state_next = S_ULEAF;
        end else begin
          push       = 1'b1;
          push_entry = '{node: node, span_a: span_a, span_b: span_b};
          if (lo <= mid) begin
            node_next   = node_l;
            span_b_next = mid;
          end else begin
            node_next   = node_r;
            span_a_next = mid_p1;
          end
        end
      end

      // The leaf addition always wraps as a sum, whatever the mode.
      S_ULEAF: begin
        cmb_mode   = MODE_SUM;
        cmb_x      = mem_rd;
        cmb_y      = amount;
        wr_en      = 1'b1;
        state_next = S_UUP;
      end

      // Pop the next ancestor and start reading its left child.
      S_UUP: begin
        if (sp == '0) begin
          state_next = S_IDLE;
        end else begin
          node_next  = stk_top.node;
          sp_next    = sp_m1;
          rd_addr    = top_l[AW-1:0];
          state_next = S_URDR;
        end
      end

      S_URDR: begin
        lval_next  = (node_l < NW'(DEPTH)) ? mem_rd : ident_cur;
        rd_addr    = node_r[AW-1:0];
        state_next = S_UWR;
      end

      S_UWR: begin
        cmb_x      = lval;
        cmb_y      = (node_r < NW'(DEPTH)) ? mem_rd : ident_cur;
        wr_en      = 1'b1;
        state_next = S_UUP;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Resume the query walk from the last saved node, or finish when none is left.
    if (do_pop) begin
      if (sp == '0) begin
        state_next = S_EMIT;
      end else begin
        node_next   = stk_top.node;
        span_a_next = stk_top.span_a;
        span_b_next = stk_top.span_b;
        sp_next     = sp_m1;
        state_next  = S_QVISIT;
      end
    end

    if (push) begin
      sp_next = sp + SPW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      sp       <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      sp       <= sp_next;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    mode   <= mode_next;
    lo     <= lo_next;
    hi     <= hi_next;
    amount <= amount_next;
    node   <= node_next;
    span_a <= span_a_next;
    span_b <= span_b_next;
    acc    <= acc_next;
    lval   <= lval_next;
  end

  // Traversal stack.
  always_ff @(posedge clk) begin
    if (push) begin
      stack[sp[SIW-1:0]] <= push_entry;
    end
  end

  // Node memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count   <= LEAF_COUNT_RST;
      combine_mode <= MODE_SUM;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LEAF_COUNT) begin
        leaf_count <= cfg_data;
      end else if (cfg_index == REG_COMBINE_MODE) begin
        combine_mode <= cfg_data[MODE_W-1:0];
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= acc;
    end
  end

  assign range_result = result;

endmodule

@@ test/range_aggregate_segment_tree_top_tb.sv @@
// Self-checking testbench for range_aggregate_segment_tree_top: point updates and range
// queries under every combine mode and a range of leaf counts, checked against an in-bench tree model.
// Depends on rast_pkg and the RTL of range_aggregate_segment_tree_top.
module range_aggregate_segment_tree_top_tb;
  import rast_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEAVES = 1024;
  localparam int unsigned TREE_NODES = 2 * MAX_LEAVES;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 78;

  typedef struct packed {
    logic                      kind;
    logic [INDEX_W-1:0]        first_idx;
    logic [INDEX_W-1:0]        last_idx;
    logic signed [DATA_W-1:0]  amount;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_UPDATE;
  logic [INDEX_W-1:0] first_index = '0;
  logic [INDEX_W-1:0] last_index = '0;
  logic signed [DATA_W-1:0] add_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] range_result;

  // Model of the node memory and the two registers.
  logic [DATA_W-1:0] node_store [0:TREE_NODES-1];
  logic [COUNT_W-1:0] leaf_count_reg = LEAF_COUNT_RST;
  logic [MODE_W-1:0] mode_reg = MODE_SUM;

  request_t pending_words [$];
  logic signed [DATA_W-1:0] awaited_results [$];
  request_t staged;
  logic signed [DATA_W-1:0] wanted;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  range_aggregate_segment_tree_top #(.MAX_LEAVES(MAX_LEAVES)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .first_index  (first_index),
    .last_index   (last_index),
    .add_value    (add_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .range_result (range_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Identity element: the unused mode code falls on minimum through bit 1.
  function automatic logic [DATA_W-1:0] mode_identity(input logic [MODE_W-1:0] mode);
    return mode[1] ? INT_MAX : ((mode == MODE_MAX) ? INT_MIN : '0);
  endfunction

  function automatic logic [DATA_W-1:0] merge(input logic [MODE_W-1:0] mode,
                                              input logic [DATA_W-1:0] x,
                                              input logic [DATA_W-1:0] y);
    if (mode[1]) begin
      return ($signed(y) < $signed(x)) ? y : x;
    end
    if (mode == MODE_MAX) begin
      return ($signed(x) < $signed(y)) ? y : x;
    end
    return x + y;
  endfunction

  // Leaf counts above the tree size act as the full tree.
  function automatic int unsigned effective_leaves();
    return (leaf_count_reg > MAX_LEAVES) ? MAX_LEAVES : int'(leaf_count_reg);
  endfunction

  function automatic logic [DATA_W-1:0] node_or_identity(input int unsigned node);
    return (node < TREE_NODES) ? node_store[node] : mode_identity(mode_reg);
  endfunction

  // Adds to one leaf, then recombines its ancestors with the current mode.
  function automatic void tree_add(input int unsigned idx, input logic [DATA_W-1:0] amount);
    int unsigned path [0:31];
    int unsigned depth;
    int unsigned node;
    int unsigned span_lo;
    int unsigned span_hi;
    int unsigned mid;
    int unsigned used;
    used = effective_leaves();
    if (used == 0 || idx >= used) begin
      return;
    end
    node = 0;
    span_lo = 0;
    span_hi = used - 1;
    depth = 0;
    while (span_lo != span_hi && node < TREE_NODES) begin
      path[depth] = node;
      depth++;
      mid = (span_lo + span_hi) / 2;
      if (idx <= mid) begin
        node = 2 * node + 1;
        span_hi = mid;
      end else begin
        node = 2 * node + 2;
        span_lo = mid + 1;
      end
    end
    if (node < TREE_NODES) begin
      node_store[node] = node_store[node] + amount;
    end
    while (depth > 0) begin
      depth--;
      node = path[depth];
      node_store[node] = merge(mode_reg, node_or_identity(2 * node + 1),
                               node_or_identity(2 * node + 2));
    end
  endfunction

  // Aggregate of stored nodes over [lo, hi]; every mode is associative and commutative, so the walk
  // order does not matter.
  function automatic logic [DATA_W-1:0] tree_query(input int unsigned lo,
                                                   input int unsigned hi);
    int unsigned st_node [0:63];
    int unsigned st_lo [0:63];
    int unsigned st_hi [0:63];
    int unsigned sp;
    int unsigned node;
    int unsigned a;
    int unsigned b;
    int unsigned mid;
    logic [DATA_W-1:0] acc;
    acc = mode_identity(mode_reg);
    if (effective_leaves() == 0) begin
      return acc;
    end
    st_node[0] = 0;
    st_lo[0] = 0;
    st_hi[0] = effective_leaves() - 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      node = st_node[sp];
      a = st_lo[sp];
      b = st_hi[sp];
      if (a > hi || b < lo || node >= TREE_NODES) begin
        continue;
      end
      if (a >= lo && b <= hi) begin
        acc = merge(mode_reg, acc, node_store[node]);
      end else begin
        mid = (a + b) / 2;
        st_node[sp] = 2 * node + 1;
        st_lo[sp] = a;
        st_hi[sp] = mid;
        st_node[sp + 1] = 2 * node + 2;
        st_lo[sp + 1] = mid + 1;
        st_hi[sp + 1] = b;
        sp += 2;
      end
    end
    return acc;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_request(input logic kind, input int unsigned lo_idx,
                               input int unsigned hi_idx, input logic signed [DATA_W-1:0] amount);
    request_t r;
    r.kind = kind;
    r.first_idx = lo_idx[INDEX_W-1:0];
    r.last_idx = hi_idx[INDEX_W-1:0];
    r.amount = amount;
    pending_words.insert(pending_words.size(), r);
  endtask

  // Register write over the configuration channel; the model follows at acceptance.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LEAF_COUNT) begin
      leaf_count_reg = value[COUNT_W-1:0];
    end else begin
      mode_reg = value[MODE_W-1:0];
    end
  endtask

  // Waits until every word is taken and answered, then lets a trailing update finish.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly in-range indexes and ordered ranges; some full-width noise.
  function automatic request_t random_request();
    request_t r;
    int unsigned used;
    int unsigned a;
    int unsigned b;
    int unsigned tmp;
    used = effective_leaves();
    r.kind = $urandom_range(0, 1) ? REQ_QUERY : REQ_UPDATE;
    if (used == 0 || $urandom_range(0, 7) == 0) begin
      a = $urandom_range(0, 1023);
      b = $urandom_range(0, 1023);
    end else begin
      a = $urandom_range(0, used - 1);
      b = $urandom_range(0, used - 1);
      if (a > b && $urandom_range(0, 9) != 0) begin
        tmp = a;
        a = b;
        b = tmp;
      end
      if ($urandom_range(0, 7) == 0) begin
        b = a;
      end
    end
    r.first_idx = a[INDEX_W-1:0];
    r.last_idx = b[INDEX_W-1:0];
    case ($urandom_range(0, 5))
      0: r.amount = $urandom;
      1: r.amount = $urandom_range(0, 1) ? INT_MAX : INT_MIN;
      default: r.amount = int'($urandom_range(0, 200)) - 100;
    endcase
    return r;
  endfunction

  // Word driver: the model is updated at each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (req_type == REQ_QUERY) begin
          awaited_results.insert(awaited_results.size(),
                                 tree_query(32'(first_index), 32'(last_index)));
        end else begin
          tree_add(32'(first_index), add_value);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        staged = pending_words.pop_front();
        req_type <= staged.kind;
        first_index <= staged.first_idx;
        last_index <= staged.last_idx;
        add_value <= staged.amount;
        in_valid <= 1'b1;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d with no query outstanding", range_result));
        end else begin
          wanted = awaited_results.pop_front();
          if (range_result !== wanted) begin
            flag_mismatch($sformatf("range_result got %0d, expected %0d",
                                    range_result, wanted));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] count;
    for (int k = 0; k < TREE_NODES; k++) begin
      node_store[k] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fresh tree under sum, then wrapping sums at the extremes.
    queue_request(REQ_QUERY, 0, 1023, 0);
    queue_request(REQ_UPDATE, 0, 1023, INT_MAX);
    queue_request(REQ_UPDATE, 1023, 0, INT_MIN);
    queue_request(REQ_UPDATE, 511, 1023, 1);
    queue_request(REQ_QUERY, 0, 1023, -1);
    queue_request(REQ_UPDATE, 0, 5, 1);
    queue_request(REQ_QUERY, 0, 0, 0);
    queue_request(REQ_QUERY, 1023, 0, 0);
    queue_request(REQ_QUERY, 512, 1023, 0);
    queue_request(REQ_UPDATE, 700, 700, -1);

    // Mode switches leave stored sums in place until an update repairs a path.
    drain();
    write_register(REG_COMBINE_MODE, CFG_DATA_W'(MODE_MAX));
    queue_request(REQ_QUERY, 0, 1023, 0);
    queue_request(REQ_UPDATE, 300, 0, 5);
    queue_request(REQ_QUERY, 0, 1023, 0);
    queue_request(REQ_QUERY, 200, 800, 0);
    drain();
    write_register(REG_COMBINE_MODE, CFG_DATA_W'(MODE_MIN));
    queue_request(REQ_QUERY, 0, 1023, 0);
    queue_request(REQ_UPDATE, 1, 0, -7);
    queue_request(REQ_QUERY, 0, 511, 0);
    drain();
    write_register(REG_COMBINE_MODE, CFG_DATA_W'(3));
    queue_request(REQ_QUERY, 0, 1023, 0);

    // Empty tree: updates vanish, queries give the identity.
    drain();
    write_register(REG_LEAF_COUNT, '0);
    queue_request(REQ_UPDATE, 3, 0, 9);
    queue_request(REQ_QUERY, 0, 1023, 0);

    // Oversized count clamps to the full tree.
    drain();
    write_register(REG_LEAF_COUNT, '1);
    write_register(REG_COMBINE_MODE, CFG_DATA_W'(MODE_SUM));
    queue_request(REQ_QUERY, 0, 1023, 0);

    // Short tree: indexes past the last leaf.
    drain();
    write_register(REG_LEAF_COUNT, CFG_DATA_W'(5));
    queue_request(REQ_UPDATE, 7, 0, 3);
    queue_request(REQ_QUERY, 2, 1000, 0);
    queue_request(REQ_QUERY, 6, 9, 0);

    drain();
    write_register(REG_LEAF_COUNT, CFG_DATA_W'(1));
    queue_request(REQ_UPDATE, 0, 0, 42);
    queue_request(REQ_QUERY, 0, 0, 0);

    // Random phases over assorted settings; the last one runs without gaps or stalls.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      in_gaps_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
      out_stalls_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
        0: count = CFG_DATA_W'($urandom_range(1, 1024));
        1: count = CFG_DATA_W'($urandom_range(1, 16));
        2: count = CFG_DATA_W'($urandom_range(1025, 2047));
        3: count = CFG_DATA_W'($urandom_range(2, 64));
        default: count = CFG_DATA_W'(MAX_LEAVES);
      endcase
      write_register(REG_LEAF_COUNT, count);
      write_register(REG_COMBINE_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      repeat (WORDS_PER_PHASE) pending_words.insert(pending_words.size(), random_request());
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rast_pkg.sv
rtl/rast_combine.sv
rtl/range_aggregate_segment_tree_top.sv
test/range_aggregate_segment_tree_top_tb.sv
